// ----- design/bgc_pkg.sv -----
// Shared types and constants for the button gesture classifier.
package bgc_pkg;

    localparam int CNT_W = 8;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam logic [CNT_W-1:0] LONG_PRESS_RST = 8'd20;
    localparam logic [CNT_W-1:0] DBL_GAP_RST    = 8'd8;
    localparam logic [CNT_W-1:0] BLINK_DIV_RST  = 8'd4;
    localparam logic [CNT_W-1:0] DBL_ON_RST     = 8'd40;

    typedef enum logic [1:0] {
        REG_LONG_PRESS = 2'd0,
        REG_DBL_GAP    = 2'd1,
        REG_BLINK_DIV  = 2'd2,
        REG_DBL_ON     = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        GEST_NONE   = 2'd0,
        GEST_SINGLE = 2'd1,
        GEST_DOUBLE = 2'd2,
        GEST_LONG   = 2'd3
    } gesture_t;

    typedef enum logic [1:0] {
        CLK_NONE = 2'd0,
        CLK_ONE  = 2'd1,
        CLK_TWO  = 2'd2
    } clicks_t;

    typedef struct packed {
        logic [CNT_W-1:0] long_limit;
        logic [CNT_W-1:0] click_window;
        logic [CNT_W-1:0] blink_divider;
        logic [CNT_W-1:0] double_on_ticks;
    } cfg_t;

endpackage

// ----- design/bgc_cfg.sv -----
// Configuration register file for the button gesture classifier.
module bgc_cfg (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [bgc_pkg::CNT_W-1:0] cfg_data,
    output bgc_pkg::cfg_t           cfg
);

    bgc_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_limit      <= bgc_pkg::LONG_PRESS_RST;
            cfg_reg.click_window    <= bgc_pkg::DBL_GAP_RST;
            cfg_reg.blink_divider   <= bgc_pkg::BLINK_DIV_RST;
            cfg_reg.double_on_ticks <= bgc_pkg::DBL_ON_RST;
        end
        else if (cfg_valid)
        begin
            case (bgc_pkg::reg_idx_t'(cfg_index))
                bgc_pkg::REG_LONG_PRESS: cfg_reg.long_limit      <= cfg_data;
                bgc_pkg::REG_DBL_GAP:    cfg_reg.click_window    <= cfg_data;
                bgc_pkg::REG_BLINK_DIV:  cfg_reg.blink_divider   <= cfg_data;
                bgc_pkg::REG_DBL_ON:     cfg_reg.double_on_ticks <= cfg_data;
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

// ----- design/bgc_core.sv -----
// Gesture state and its per-sample next-state logic.
module bgc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              btn,
    input  logic              tick,
    input  bgc_pkg::cfg_t     cfg,
    output logic              led_next_o,
    output bgc_pkg::gesture_t gesture_o
);

    logic                       led_reg, led_next;
    logic                       holding_reg, holding_next;
    logic                       long_reg, long_next;
    logic [bgc_pkg::CNT_W-1:0]  press_reg, press_next;
    bgc_pkg::clicks_t           clicks_reg, clicks_next;
    logic [bgc_pkg::CNT_W-1:0]  gap_reg, gap_next;
    logic                       blinking_reg, blinking_next;
    logic [bgc_pkg::CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [bgc_pkg::CNT_W-1:0]  onhold_reg, onhold_next;
    bgc_pkg::gesture_t          gesture;
    logic                       consumed;

    always_comb
    begin
        led_next      = led_reg;
        holding_next  = holding_reg;
        long_next     = long_reg;
        press_next    = press_reg;
        clicks_next   = clicks_reg;
        gap_next      = gap_reg;
        blinking_next = blinking_reg;
        bcnt_next     = bcnt_reg;
        onhold_next   = onhold_reg;
        gesture       = bgc_pkg::GEST_NONE;
        consumed      = 1'b0;

        if (onhold_reg != '0)
        begin
            // LED held lit after a double click: button ignored
            holding_next = 1'b0;
            long_next    = 1'b0;
            press_next   = '0;
            if (tick)
            begin
                onhold_next = onhold_reg - 1'b1;
                if (onhold_reg == bgc_pkg::CNT_W'(1))
                begin
                    led_next      = 1'b0;
                    blinking_next = 1'b0;
                end
            end
        end
        else
        begin
            if (btn)
            begin
                if (!holding_reg)
                begin
                    holding_next = 1'b1;
                    press_next   = '0;
                    long_next    = 1'b0;
                end
                if (!long_next && tick)
                begin
                    consumed = 1'b1;
                    if (press_next != bgc_pkg::CNT_MAX)
                        press_next = press_next + 1'b1;
                    if (press_next >= cfg.long_limit)
                    begin
                        long_next = 1'b1;
                        if (!blinking_reg)
                            bcnt_next = '0;
                        blinking_next = 1'b1;
                        gesture       = bgc_pkg::GEST_LONG;
                    end
                end
            end
            else if (holding_reg)
            begin
                holding_next = 1'b0;
                // release after a long press is not a click
                if (!long_reg)
                begin
                    if (clicks_reg != bgc_pkg::CLK_TWO)
                        clicks_next = bgc_pkg::clicks_t'(clicks_reg + 2'd1);
                    gap_next = '0;
                end
                long_next  = 1'b0;
                press_next = '0;
            end

            if (tick && !consumed)
            begin
                if (blinking_next)
                begin
                    bcnt_next = bcnt_next + 1'b1;
                    if (bcnt_next >= cfg.blink_divider)
                    begin
                        bcnt_next = '0;
                        led_next  = ~led_next;
                    end
                end
                case (clicks_next)
                    bgc_pkg::CLK_ONE:
                    begin
                        if (gap_next != bgc_pkg::CNT_MAX)
                            gap_next = gap_next + 1'b1;
                        if (gap_next >= cfg.click_window)
                        begin
                            led_next    = ~led_next;
                            clicks_next = bgc_pkg::CLK_NONE;
                            gap_next    = '0;
                            gesture     = bgc_pkg::GEST_SINGLE;
                        end
                    end
                    bgc_pkg::CLK_TWO:
                    begin
                        led_next     = 1'b1;
                        onhold_next  = (cfg.double_on_ticks == '0) ?
                                       bgc_pkg::CNT_W'(1) : cfg.double_on_ticks;
                        clicks_next  = bgc_pkg::CLK_NONE;
                        gap_next     = '0;
                        holding_next = 1'b0;
                        long_next    = 1'b0;
                        press_next   = '0;
                        gesture      = bgc_pkg::GEST_DOUBLE;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg      <= 1'b0;
            holding_reg  <= 1'b0;
            long_reg     <= 1'b0;
            press_reg    <= '0;
            clicks_reg   <= bgc_pkg::CLK_NONE;
            gap_reg      <= '0;
            blinking_reg <= 1'b0;
            bcnt_reg     <= '0;
            onhold_reg   <= '0;
        end
        else if (en)
        begin
            led_reg      <= led_next;
            holding_reg  <= holding_next;
            long_reg     <= long_next;
            press_reg    <= press_next;
            clicks_reg   <= clicks_next;
            gap_reg      <= gap_next;
            blinking_reg <= blinking_next;
            bcnt_reg     <= bcnt_next;
            onhold_reg   <= onhold_next;
        end
    end

    assign led_next_o = led_next;
    assign gesture_o  = gesture;

    // a double click always lights the LED
    a_double_lights: assert property (@(posedge clk) disable iff (!rst_n)
        gesture == bgc_pkg::GEST_DOUBLE |-> led_next)
        else $error("double click without LED lit");

    // click count never reaches the unused code
    a_clicks_sat: assert property (@(posedge clk) disable iff (!rst_n)
        clicks_reg != 2'd3)
        else $error("click count past saturation");

    // no press is tracked while the LED is held lit
    a_hold_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        en && onhold_reg != '0 |=> !holding_reg && press_reg == '0)
        else $error("press tracked during lit hold");

endmodule

// ----- design/button_gesture_classifier.sv -----
// Button gesture classifier top level: input stage, gesture core, result stage.
//
// One input word per sample: button_down (debounced level) and tick (one timer
// tick elapsed). Every accepted word yields exactly one result word: led_on,
// the LED level after that sample, and gesture (0 none, 1 single click,
// 2 double click, 3 long press).
// Input and output channels use valid/ready. An accepted word sits in the input
// register, is evaluated against the gesture state and moves into the result
// register when that is empty or being taken. Throughput is one word per cycle
// while the receiver takes results; the state update is a single pass of counter
// compares from the input register to the result register.
// When the receiver stalls, the result word holds and one more word waits in
// the input register; in_ready drops only when both are full.
// Config writes (cfg_index 0..3: long press ticks, double click gap, blink
// divider, double-on ticks) are taken every cycle and belong in idle periods.
// Reset (rst_n, async, active low) empties both stages, clears the core's LED
// level and all gesture state and loads the default register values 20/8/4/40.
module button_gesture_classifier (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      button_down,
    input  logic                      tick,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      led_on,
    output logic [1:0]                gesture,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [bgc_pkg::CNT_W-1:0] cfg_data
);

    bgc_pkg::cfg_t     cfg;
    logic              s1_valid_reg;
    logic              s1_btn_reg;
    logic              s1_tick_reg;
    logic              out_valid_reg;
    logic              led_reg;
    logic [1:0]        gesture_reg;
    logic              advance;
    logic              core_led;
    bgc_pkg::gesture_t core_gesture;

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    bgc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .btn        (s1_btn_reg),
        .tick       (s1_tick_reg),
        .cfg        (cfg),
        .led_next_o (core_led),
        .gesture_o  (core_gesture)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_btn_reg  <= button_down;
            s1_tick_reg <= tick;
        end
        if (advance)
        begin
            led_reg     <= core_led;
            gesture_reg <= core_gesture;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_on    = led_reg;
    assign gesture   = gesture_reg;

    // backpressure only when both stages hold a word
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled with room in the pipe");

    // a waiting word with an empty result stage moves on at the next edge
    a_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("word stuck in input stage");

    // an untaken result is not overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

// ----- dv/button_gesture_classifier_check.sv -----
// Checker for the button gesture classifier: mirrors the gesture state and scores every result word.
module button_gesture_classifier_check (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      button_down,
    input  logic                      tick,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      led_on,
    input  logic [1:0]                gesture,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [bgc_pkg::CNT_W-1:0] cfg_data,
    output int                        mismatches,
    output int                        outstanding,
    output int                        results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              led;
        bgc_pkg::gesture_t gest;
    } led_gesture_t;

    // expected LED level and gesture per accepted sample, oldest first
    led_gesture_t led_gesture_q[$];

    bgc_pkg::cfg_t             regs;
    logic                      led;
    logic                      pressed;
    logic                      latched;
    logic [bgc_pkg::CNT_W-1:0] press_ticks;
    bgc_pkg::clicks_t          click_cnt;
    logic [bgc_pkg::CNT_W-1:0] gap_ticks;
    logic                      blink_mode;
    logic [bgc_pkg::CNT_W-1:0] blink_ticks;
    logic [bgc_pkg::CNT_W-1:0] lit_left;

    function automatic led_gesture_t classify_sample(input logic btn, input logic tk);
        led_gesture_t      res;
        logic              consumed;
        bgc_pkg::gesture_t g;
        consumed = 1'b0;
        g = bgc_pkg::GEST_NONE;
        if (lit_left != '0) begin
            // lit after a double click: button ignored, press dropped
            pressed = 1'b0;
            latched = 1'b0;
            press_ticks = '0;
            if (tk) begin
                lit_left = lit_left - 1'b1;
                if (lit_left == '0) begin
                    led = 1'b0;
                    blink_mode = 1'b0;
                end
            end
        end
        else begin
            if (btn) begin
                if (!pressed) begin
                    pressed = 1'b1;
                    press_ticks = '0;
                    latched = 1'b0;
                end
                // a tick during an unlatched press only times the press
                if (!latched && tk) begin
                    consumed = 1'b1;
                    if (press_ticks != bgc_pkg::CNT_MAX)
                        press_ticks = press_ticks + 1'b1;
                    if (press_ticks >= regs.long_limit) begin
                        latched = 1'b1;
                        if (!blink_mode)
                            blink_ticks = '0;
                        blink_mode = 1'b1;
                        g = bgc_pkg::GEST_LONG;
                    end
                end
            end
            else if (pressed) begin
                pressed = 1'b0;
                if (!latched) begin
                    if (click_cnt != bgc_pkg::CLK_TWO)
                        click_cnt = bgc_pkg::clicks_t'(click_cnt + 2'd1);
                    gap_ticks = '0;
                end
                latched = 1'b0;
                press_ticks = '0;
            end

            if (tk && !consumed) begin
                if (blink_mode) begin
                    blink_ticks = blink_ticks + 1'b1;
                    if (blink_ticks >= regs.blink_divider) begin
                        blink_ticks = '0;
                        led = ~led;
                    end
                end
                if (click_cnt == bgc_pkg::CLK_ONE) begin
                    if (gap_ticks != bgc_pkg::CNT_MAX)
                        gap_ticks = gap_ticks + 1'b1;
                    if (gap_ticks >= regs.click_window) begin
                        led = ~led;
                        click_cnt = bgc_pkg::CLK_NONE;
                        gap_ticks = '0;
                        g = bgc_pkg::GEST_SINGLE;
                    end
                end
                else if (click_cnt == bgc_pkg::CLK_TWO) begin
                    led = 1'b1;
                    lit_left = (regs.double_on_ticks == '0) ? 8'd1 : regs.double_on_ticks;
                    click_cnt = bgc_pkg::CLK_NONE;
                    gap_ticks = '0;
                    pressed = 1'b0;
                    latched = 1'b0;
                    press_ticks = '0;
                    g = bgc_pkg::GEST_DOUBLE;
                end
            end
        end
        res.led = led;
        res.gest = g;
        return res;
    endfunction

    function automatic void note_mismatch(input string what, input int exp_v, input int got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: result %0d %s expected %0d got %0d",
                     $realtime, results_checked, what, exp_v, got_v);
    endfunction

    assign outstanding = led_gesture_q.size();

    initial
    begin
        mismatches = 0;
        results_checked = 0;
    end

    always @(posedge clk)
    begin
        led_gesture_t exp_w;
        if (!rst_n) begin
            regs.long_limit = bgc_pkg::LONG_PRESS_RST;
            regs.click_window = bgc_pkg::DBL_GAP_RST;
            regs.blink_divider = bgc_pkg::BLINK_DIV_RST;
            regs.double_on_ticks = bgc_pkg::DBL_ON_RST;
            led = 1'b0;
            pressed = 1'b0;
            latched = 1'b0;
            press_ticks = '0;
            click_cnt = bgc_pkg::CLK_NONE;
            gap_ticks = '0;
            blink_mode = 1'b0;
            blink_ticks = '0;
            lit_left = '0;
            led_gesture_q.delete();
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (bgc_pkg::reg_idx_t'(cfg_index))
                    bgc_pkg::REG_LONG_PRESS: regs.long_limit = cfg_data;
                    bgc_pkg::REG_DBL_GAP:    regs.click_window = cfg_data;
                    bgc_pkg::REG_BLINK_DIV:  regs.blink_divider = cfg_data;
                    bgc_pkg::REG_DBL_ON:     regs.double_on_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (led_gesture_q.size() == 0) begin
                    note_mismatch("arrived with nothing expected, gesture", -1, int'(gesture));
                end
                else begin
                    exp_w = led_gesture_q.pop_front();
                    if (led_on !== exp_w.led)
                        note_mismatch("led_on", int'(exp_w.led), int'(led_on));
                    if (gesture !== exp_w.gest)
                        note_mismatch("gesture", int'(exp_w.gest), int'(gesture));
                end
                results_checked++;
            end
            if (in_valid && in_ready)
                led_gesture_q.push_back(classify_sample(button_down, tick));
        end
    end
endmodule

// ----- dv/button_gesture_classifier_test.sv -----
// Testbench top for the button gesture classifier: stimulus, flow control, verdict.
module button_gesture_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TIMEOUT_CYCLES = 500000;
    localparam int HOLD_OFF_CYCLES = 64;

    typedef enum {PLAY_MIX, PLAY_SINGLE, PLAY_DOUBLE, PLAY_LONG} play_t;

    // {button_down, tick} per word: single click, triple click (saturates at two)
    // with presses during the lit hold, then a long press into blinking
    localparam logic [1:0] DIRECTED [18] = '{
        2'b00,
        2'b10, 2'b00, 2'b01, 2'b01,
        2'b10, 2'b00, 2'b10, 2'b00, 2'b10, 2'b00, 2'b01,
        2'b11, 2'b11, 2'b00,
        2'b11, 2'b11, 2'b11
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      button_down = 1'b0;
    logic                      tick = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      led_on;
    logic [1:0]                gesture;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_index = bgc_pkg::REG_LONG_PRESS;
    logic [bgc_pkg::CNT_W-1:0] cfg_data = '0;

    int            mismatches;
    int            outstanding;
    int            results_checked;
    int            cycle_count = 0;
    int            words_sent = 0;
    int            settings_used = 0;
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;
    bgc_pkg::cfg_t settings;

    button_gesture_classifier dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .button_down (button_down),
        .tick        (tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .led_on      (led_on),
        .gesture     (gesture),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    button_gesture_classifier_check check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .button_down     (button_down),
        .tick            (tick),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .led_on          (led_on),
        .gesture         (gesture),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
            $display("button_gesture_classifier regression: fail");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests) begin
            out_ready <= 1'b0;
            hold_served <= hold_requests;
            hold_left <= HOLD_OFF_CYCLES - 1;
        end
        else begin
            out_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // valid stays high between back-to-back words; it only drops at the start of a gap
    task automatic send_word(input logic btn, input logic tk);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid <= 1'b1;
        button_down <= btn;
        tick <= tk;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // hold the button level until nticks ticks have gone by
    task automatic hold_level(input logic btn, input int nticks);
        int   seen;
        logic tk;
        seen = 0;
        if (nticks == 0)
            send_word(btn, 1'b0);
        while (seen < nticks) begin
            tk = ($urandom_range(3, 0) != 0);
            send_word(btn, tk);
            if (tk)
                seen++;
        end
    endtask

    task automatic short_click();
        int lp;
        lp = int'(settings.long_limit);
        hold_level(1'b1, (lp > 1) ? $urandom_range(lp - 1, 0) : 0);
        hold_level(1'b0, 0);
    endtask

    task automatic play_gestures(input int count, input play_t kind);
        play_t pick;
        int    r;
        int    gap;
        for (int i = 0; i < count; i++) begin
            pick = kind;
            if (kind == PLAY_MIX) begin
                r = $urandom_range(99, 0);
                pick = (r < 30) ? PLAY_SINGLE : (r < 55) ? PLAY_DOUBLE :
                       (r < 80) ? PLAY_LONG : PLAY_MIX;
            end
            gap = int'(settings.click_window);
            case (pick)
                PLAY_SINGLE: begin
                    short_click();
                    hold_level(1'b0, gap + $urandom_range(2, 0));
                end
                PLAY_DOUBLE: begin
                    short_click();
                    hold_level(1'b0, (gap > 1) ? $urandom_range(gap - 1, 0) : 0);
                    short_click();
                    // random level into the lit hold: presses while it lasts are dropped
                    hold_level(1'($urandom_range(1, 0)), int'(settings.double_on_ticks) + 2);
                    hold_level(1'b0, 0);
                end
                PLAY_LONG: begin
                    hold_level(1'b1, int'(settings.long_limit) + $urandom_range(3, 0));
                    hold_level(1'b0, $urandom_range(2 * int'(settings.blink_divider) + 1, 0));
                end
                default: begin
                    repeat ($urandom_range(6, 1))
                        send_word(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                end
            endcase
        end
    endtask

    // start at the next edge so the word accepted at the last edge is already counted
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input bgc_pkg::cfg_t s, input int idle_pct, input int stall);
        bgc_pkg::reg_idx_t idx;
        wait_drained();
        settings = s;
        for (int i = 0; i < 4; i++) begin
            idx = bgc_pkg::reg_idx_t'(i);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            case (idx)
                bgc_pkg::REG_LONG_PRESS: cfg_data <= s.long_limit;
                bgc_pkg::REG_DBL_GAP:    cfg_data <= s.click_window;
                bgc_pkg::REG_BLINK_DIV:  cfg_data <= s.blink_divider;
                bgc_pkg::REG_DBL_ON:     cfg_data <= s.double_on_ticks;
                default:                 cfg_data <= '0;
            endcase
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        settings_used++;
    endtask

    initial
    begin
        bgc_pkg::cfg_t s;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings('{8'd2, 8'd2, 8'd1, 8'd2}, 0, 0);
        foreach (DIRECTED[i])
            send_word(DIRECTED[i][1], DIRECTED[i][0]);

        load_settings('{8'd5, 8'd3, 8'd2, 8'd4}, 0, 0);
        play_gestures(4, PLAY_MIX);
        load_settings('{8'd1, 8'd1, 8'd1, 8'd1}, 88, 0);
        play_gestures(4, PLAY_MIX);
        load_settings('{8'd255, 8'd1, 8'd3, 8'd255}, 0, 88);
        play_gestures(1, PLAY_LONG);
        load_settings('{8'd1, 8'd255, 8'd1, 8'd255}, 22, 22);
        play_gestures(1, PLAY_SINGLE);
        load_settings('{8'd0, 8'd0, 8'd0, 8'd0}, 22, 22);
        play_gestures(4, PLAY_MIX);

        // receiver holds off while the sender keeps pushing
        load_settings('{8'd3, 8'd2, 8'd3, 8'd6}, 0, 0);
        hold_requests <= hold_requests + 1;
        play_gestures(4, PLAY_MIX);

        s.long_limit = 8'($urandom_range(8, 1));
        s.click_window = 8'($urandom_range(6, 1));
        s.blink_divider = 8'($urandom_range(5, 1));
        s.double_on_ticks = 8'($urandom_range(8, 1));
        load_settings(s, 0, 88);
        play_gestures(4, PLAY_MIX);

        wait_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d sample words under %0d register settings, %0d results checked",
                 words_sent, settings_used, results_checked);
        $display("covered clicks, double clicks, long presses, lit hold, blinking,");
        $display("zero and full registers");
        if (mismatches == 0 && outstanding == 0)
            $display("button_gesture_classifier regression: pass");
        else
            $display("button_gesture_classifier regression: fail");
        $finish;
    end
endmodule

// ----- filelist.f -----
design/bgc_pkg.sv
design/bgc_cfg.sv
design/bgc_core.sv
design/button_gesture_classifier.sv
dv/button_gesture_classifier_check.sv
dv/button_gesture_classifier_test.sv
